// ===== rtl/ucrr_pkg.sv =====
// Package with shared constants, types and codes of the control request responder.
package ucrr_pkg;

    localparam int DIR_ENTRIES_DEF    = 8;
    localparam int DESC_MEM_BYTES_DEF = 256;
    localparam int MAX_DESC_LEN_DEF   = 63;

    localparam logic [6:0] PKT_SIZE_RESET = 7'd32;
    localparam logic [6:0] PKT_SIZE_MAX   = 7'd64;

    // Input operations.
    localparam logic [1:0] FUNC_BUS_RESET = 2'd0;
    localparam logic [1:0] FUNC_SETUP     = 2'd1;
    localparam logic [1:0] FUNC_DIR_WRITE = 2'd2;
    localparam logic [1:0] FUNC_MEM_WRITE = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ZLP   = 2'd1;
    localparam logic [1:0] KIND_STALL = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    // Request keys, direction bit removed.
    localparam logic [14:0] KEY_GET_STATUS      = 15'h0000;
    localparam logic [14:0] KEY_SET_ADDRESS     = 15'h0005;
    localparam logic [14:0] KEY_GET_DESC        = 15'h0006;
    localparam logic [14:0] KEY_GET_DESC_IF     = 15'h0106;
    localparam logic [14:0] KEY_GET_CONFIG      = 15'h0008;
    localparam logic [14:0] KEY_SET_CONFIG      = 15'h0009;
    localparam logic [14:0] KEY_HID_SET_REPORT  = 15'h2109;
    localparam logic [14:0] KEY_HID_SET_IDLE    = 15'h210a;
    localparam logic [14:0] KEY_HUB_GET_STATUS  = 15'h2300;
    localparam logic [14:0] KEY_HUB_SET_FEATURE = 15'h2303;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] req_value;
        logic [15:0] req_index;
        logic [15:0] req_length;
        logic [2:0]  slot;
        logic [7:0]  byte_address;
        logic [7:0]  byte_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       packet_end;
        logic       run_last;
        logic [6:0] device_address;
        logic       address_enabled;
        logic [7:0] configuration;
    } out_item_t;

endpackage

// ===== rtl/ucrr_dir.sv =====
// Descriptor directory: entry registers with valid bits and a slot-at-a-time read.
module ucrr_dir #(
    parameter int DIR_ENTRIES  = ucrr_pkg::DIR_ENTRIES_DEF,
    parameter int MAX_DESC_LEN = ucrr_pkg::MAX_DESC_LEN_DEF,
    parameter int AW           = 8,
    parameter int SW           = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [2:0]    wr_slot,
    input  logic [15:0]   wr_value,
    input  logic [15:0]   wr_index,
    input  logic [15:0]   wr_length,
    input  logic [AW-1:0] wr_start,
    input  logic [SW-1:0] rd_slot,
    output logic [15:0]   rd_value,
    output logic [15:0]   rd_index,
    output logic [5:0]    rd_length,
    output logic [AW-1:0] rd_start
);
    import ucrr_pkg::*;

    logic [15:0]            value_reg [DIR_ENTRIES];
    logic [15:0]            index_reg [DIR_ENTRIES];
    logic [5:0]             len_reg   [DIR_ENTRIES];
    logic [AW-1:0]          start_reg [DIR_ENTRIES];
    logic [DIR_ENTRIES-1:0] valid_reg;
    logic [5:0]             len_sat;
    logic                   slot_ok;

    assign len_sat = (wr_length > 16'(MAX_DESC_LEN)) ? 6'(MAX_DESC_LEN) : wr_length[5:0];
    assign slot_ok = {29'd0, wr_slot} < DIR_ENTRIES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en && slot_ok)
        begin
            valid_reg[SW'(wr_slot)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && slot_ok)
        begin
            value_reg[SW'(wr_slot)] <= wr_value;
            index_reg[SW'(wr_slot)] <= wr_index;
            len_reg[SW'(wr_slot)]   <= len_sat;
            start_reg[SW'(wr_slot)] <= wr_start;
        end
    end

    // An unwritten entry reads as length zero, which ends the scan.
    assign rd_value  = value_reg[rd_slot];
    assign rd_index  = index_reg[rd_slot];
    assign rd_length = valid_reg[rd_slot] ? len_reg[rd_slot] : 6'd0;
    assign rd_start  = start_reg[rd_slot];

endmodule

// ===== rtl/ucrr_mem.sv =====
// Descriptor byte memory: one write port, one registered read port.
module ucrr_mem #(
    parameter int DESC_MEM_BYTES = ucrr_pkg::DESC_MEM_BYTES_DEF,
    parameter int AW             = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DESC_MEM_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/usb_control_request_responder_core.sv =====
// Top level of the control request responder: sequencer, state and output register.
//
// The block takes one input word at a time and is not ready while that word is
// being answered. Bus reset and setup requests other than Get Descriptor give
// their one or two result words, the first through the decode state ST_EMIT
// and the output state ST_EMIT2. Get Descriptor walks the directory one entry
// per cycle through a single key comparator (up to DIR_ENTRIES entries), then
// streams each byte through the registered descriptor memory read port with
// separate byte and packet counters, each byte passing a read state and an
// output state that waits while an earlier result has not been taken.
// Directory and memory writes are made when the word is accepted and give no result.
module usb_control_request_responder_core #(
    parameter int DIR_ENTRIES    = ucrr_pkg::DIR_ENTRIES_DEF,
    parameter int DESC_MEM_BYTES = ucrr_pkg::DESC_MEM_BYTES_DEF,
    parameter int MAX_DESC_LEN   = ucrr_pkg::MAX_DESC_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func, request_type, request_code, req_value, req_index, req_length,
    // slot, byte_address, byte_data (lowest bit up), 3 zero bits on top
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind, data_byte, packet_end, run_last, device_address, address_enabled,
    // configuration (lowest bit up), 4 zero bits on top
    output logic [31:0] m_tdata
);
    import ucrr_pkg::*;

    localparam int AW = $clog2(DESC_MEM_BYTES);
    localparam int SW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int CW = $clog2(DIR_ENTRIES + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_BYTE  = 7'b0001000,
        ST_ZLP   = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_EMIT2 = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    in_item_t    in_item;
    in_item_t    req_reg;
    logic [6:0]  pkt_size_reg;
    logic [6:0]  dev_addr_reg, dev_addr_next;
    logic        addr_en_reg, addr_en_next;
    logic [7:0]  config_reg, config_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [5:0]  sent_reg, sent_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [6:0]  pkt_reg, pkt_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  dbyte_reg, dbyte_next;
    logic        second_reg, second_next;
    logic        ovalid_reg;
    out_item_t   out_reg;
    logic        push;
    out_item_t   push_item;
    logic [6:0]  pkt_size;
    logic [14:0] key;
    logic        in_acc;

    logic [15:0]   d_value, d_index;
    logic [5:0]    d_length;
    logic [AW-1:0] d_start;
    logic [7:0]    m_rd;
    logic          match;

    // The struct lists func in its top bits, the bus carries it in the lowest.
    assign in_item   = {s_tdata[1:0], s_tdata[9:2], s_tdata[17:10], s_tdata[33:18],
                        s_tdata[49:34], s_tdata[65:50], s_tdata[68:66], s_tdata[76:69],
                        s_tdata[84:77]};
    assign s_tready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign key       = {req_reg.request_type[6:0], req_reg.request_code};
    assign pkt_size  = (pkt_size_reg == 7'd0) ? 7'd1 :
                       (pkt_size_reg > PKT_SIZE_MAX) ? PKT_SIZE_MAX : pkt_size_reg;

    ucrr_dir #(.DIR_ENTRIES(DIR_ENTRIES), .MAX_DESC_LEN(MAX_DESC_LEN), .AW(AW), .SW(SW))
    u_dir (
        .clk, .rst_n,
        .wr_en    (in_acc && in_item.func == FUNC_DIR_WRITE),
        .wr_slot  (in_item.slot),
        .wr_value (in_item.req_value),
        .wr_index (in_item.req_index),
        .wr_length(in_item.req_length),
        .wr_start (AW'(in_item.byte_address)),
        .rd_slot  (scan_reg[SW-1:0]),
        .rd_value (d_value),
        .rd_index (d_index),
        .rd_length(d_length),
        .rd_start (d_start)
    );

    ucrr_mem #(.DESC_MEM_BYTES(DESC_MEM_BYTES), .AW(AW)) u_mem (
        .clk,
        .wr_en  (in_acc && in_item.func == FUNC_MEM_WRITE),
        .wr_addr(AW'(in_item.byte_address)),
        .wr_data(in_item.byte_data),
        .rd_addr(addr_reg),
        .rd_data(m_rd)
    );

    assign match = (d_value == req_reg.req_value) && (d_index == req_reg.req_index);

    always_comb
    begin
        state_next    = state_reg;
        dev_addr_next = dev_addr_reg;
        addr_en_next  = addr_en_reg;
        config_next   = config_reg;
        scan_next     = scan_reg;
        sent_next     = sent_reg;
        cnt_next      = cnt_reg;
        pkt_next      = pkt_reg;
        addr_next     = addr_reg;
        kind_next     = kind_reg;
        dbyte_next    = dbyte_reg;
        second_next   = second_reg;
        push          = 1'b0;
        push_item     = '0;
        push_item.device_address  = dev_addr_reg;
        push_item.address_enabled = addr_en_reg;
        push_item.configuration   = config_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_item.func == FUNC_BUS_RESET || in_item.func == FUNC_SETUP))
                begin
                    state_next = ST_EMIT;
                    scan_next  = '0;
                end
            end
            ST_EMIT:
            begin
                // Decode the held request and update state first.
                second_next = 1'b0;
                dbyte_next  = 8'd0;
                if (req_reg.func == FUNC_BUS_RESET)
                begin
                    config_next = 8'd0;
                    kind_next   = KIND_RESET;
                    state_next  = ST_EMIT2;
                end
                else
                begin
                    state_next = ST_EMIT2;
                    priority case (key)
                        KEY_GET_STATUS:
                        begin
                            kind_next   = KIND_DATA;
                            second_next = 1'b1;
                        end
                        KEY_SET_ADDRESS:
                        begin
                            dev_addr_next = req_reg.req_value[6:0];
                            addr_en_next  = 1'b1;
                            kind_next     = KIND_ZLP;
                        end
                        KEY_GET_DESC, KEY_GET_DESC_IF:
                        begin
                            state_next = ST_SCAN;
                        end
                        KEY_GET_CONFIG:
                        begin
                            kind_next  = KIND_DATA;
                            dbyte_next = config_reg;
                        end
                        KEY_SET_CONFIG:
                        begin
                            config_next = req_reg.req_value[7:0];
                            kind_next   = KIND_ZLP;
                        end
                        KEY_HID_SET_REPORT, KEY_HID_SET_IDLE,
                        KEY_HUB_GET_STATUS, KEY_HUB_SET_FEATURE:
                        begin
                            kind_next = KIND_ZLP;
                        end
                        default:
                        begin
                            kind_next = KIND_STALL;
                        end
                    endcase
                end
            end
            ST_EMIT2:
            begin
                if (!ovalid_reg)
                begin
                    push                 = 1'b1;
                    push_item.kind       = kind_reg;
                    push_item.data_byte  = dbyte_reg;
                    push_item.packet_end = (kind_reg == KIND_DATA) &&
                                           (req_reg.func == FUNC_SETUP) &&
                                           (second_reg || key == KEY_GET_CONFIG) &&
                                           !(second_reg && 1'b0);
                    push_item.run_last   = 1'b1;
                    if (second_reg)
                    begin
                        // First of the two Get Status bytes.
                        push_item.packet_end = 1'b0;
                        push_item.run_last   = 1'b0;
                        second_next          = 1'b0;
                        kind_next            = KIND_DATA;
                        dbyte_next           = 8'd0;
                        state_next           = ST_ZLP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == CW'(DIR_ENTRIES) || d_length == 6'd0)
                begin
                    kind_next   = KIND_STALL;
                    dbyte_next  = 8'd0;
                    second_next = 1'b0;
                    state_next  = ST_EMIT2;
                end
                else if (match)
                begin
                    sent_next  = ({10'd0, d_length} < req_reg.req_length) ?
                                 d_length : req_reg.req_length[5:0];
                    cnt_next   = 6'd0;
                    pkt_next   = 7'd0;
                    addr_next  = d_start;
                    state_next = (({10'd0, d_length} < req_reg.req_length) ||
                                  (req_reg.req_length != 16'd0)) ? ST_READ : ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            ST_READ:
            begin
                // Memory address is presented; data is registered next cycle.
                state_next = (cnt_reg == sent_reg) ? ST_ZLP : ST_BYTE;
                if (cnt_reg == sent_reg)
                begin
                    kind_next = KIND_ZLP;
                    if (!(pkt_reg == 7'd0 && req_reg.req_length > {10'd0, sent_reg}))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BYTE:
            begin
                if (!ovalid_reg)
                begin
                    push                 = 1'b1;
                    push_item.kind       = KIND_DATA;
                    push_item.data_byte  = m_rd;
                    push_item.packet_end = (pkt_reg + 7'd1 == pkt_size) ||
                                           (cnt_reg + 6'd1 == sent_reg);
                    push_item.run_last   = (cnt_reg + 6'd1 == sent_reg) &&
                                           !((pkt_reg + 7'd1 == pkt_size) &&
                                             req_reg.req_length > {10'd0, sent_reg});
                    pkt_next  = (pkt_reg + 7'd1 == pkt_size) ? 7'd0 : pkt_reg + 7'd1;
                    cnt_next  = cnt_reg + 6'd1;
                    addr_next = addr_reg + AW'(1);
                    state_next = ST_READ;
                end
            end
            ST_ZLP:
            begin
                if (!ovalid_reg)
                begin
                    push                 = 1'b1;
                    push_item.kind       = kind_reg;
                    push_item.data_byte  = 8'd0;
                    push_item.packet_end = (kind_reg == KIND_DATA);
                    push_item.run_last   = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pkt_size_reg <= PKT_SIZE_RESET;
            dev_addr_reg <= '0;
            addr_en_reg  <= 1'b0;
            config_reg   <= '0;
            ovalid_reg   <= 1'b0;
            scan_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dev_addr_reg <= dev_addr_next;
            addr_en_reg  <= addr_en_next;
            config_reg   <= config_next;
            scan_reg     <= scan_next;
            if (cfg_valid)
            begin
                pkt_size_reg <= cfg_data;
            end
            if (push)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= in_item;
        end
        sent_reg   <= sent_next;
        cnt_reg    <= cnt_next;
        pkt_reg    <= pkt_next;
        addr_reg   <= addr_next;
        kind_reg   <= kind_next;
        dbyte_reg  <= dbyte_next;
        second_reg <= second_next;
        if (push)
        begin
            out_reg <= push_item;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, out_reg.configuration, out_reg.address_enabled,
                       out_reg.device_address, out_reg.run_last, out_reg.packet_end,
                       out_reg.data_byte, out_reg.kind};

endmodule
